// ===== src/assert_macros.svh =====
// assertion macros shared by the stream walker rtl
// each macro expects clk_i and rst_ni in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== src/dtw_pkg.sv =====
// types, codes and helpers for the der tlv stream walker
// no dependencies; used by every module of the block
package dtw_pkg;

  // result slots of a bundle (one byte causes at most three results)
  localparam int MaxRes = 4;
  localparam int CntW   = 3;

  // parse modes
  localparam logic [2:0] MODE_TAG  = 3'd0;
  localparam logic [2:0] MODE_LEN  = 3'd1;
  localparam logic [2:0] MODE_LONG = 3'd2;
  localparam logic [2:0] MODE_OID  = 3'd3;
  localparam logic [2:0] MODE_HALT = 3'd4;

  // event kinds
  localparam logic [3:0] EV_SEQ    = 4'd0;
  localparam logic [3:0] EV_CONS   = 4'd1;
  localparam logic [3:0] EV_OIDTAG = 4'd2;
  localparam logic [3:0] EV_LENGTH = 4'd3;
  localparam logic [3:0] EV_ARC    = 4'd4;
  localparam logic [3:0] EV_OIDEND = 4'd5;
  localparam logic [3:0] EV_BADTAG = 4'd6;
  localparam logic [3:0] EV_BADLEN = 4'd7;
  localparam logic [3:0] EV_TRUNC  = 4'd8;

  // tag bytes and masks
  localparam logic [7:0] TagSeq  = 8'h30;
  localparam logic [7:0] TagSet  = 8'h31;
  localparam logic [7:0] TagOid  = 8'h06;
  localparam logic [7:0] ConsBit = 8'h20;

  // length limit
  localparam logic [2:0] MaxLenOctets = 3'd4;

  // first arc split points
  localparam logic [31:0] ArcSplit1 = 32'd40;
  localparam logic [31:0] ArcSplit2 = 32'd80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_end;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  event_kind;
    logic [7:0]  tag_value;
    logic [31:0] event_value;
    logic        last_of_run;
  } out_item_t;

  // results of one byte, in order, with their count
  typedef struct packed {
    out_item_t [MaxRes-1:0] ents;
    logic [CntW-1:0]        cnt;
  } res_bundle_t;

  function automatic out_item_t mk_item(logic [3:0] kind, logic [7:0] tag,
                                        logic [31:0] val);
    out_item_t r;
    r.event_kind  = kind;
    r.tag_value   = tag;
    r.event_value = val;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

// ===== src/dtw_parse.sv =====
// parser state and per-byte decode for the der tlv stream walker
// depends on dtw_pkg and assert_macros.svh
`include "assert_macros.svh"
module dtw_parse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_wdata_i,
  input  logic                 fire_i,
  input  dtw_pkg::in_item_t    item_i,
  output dtw_pkg::res_bundle_t bundle_o
);
  import dtw_pkg::*;

  logic [2:0]  limit_q;
  logic [2:0]  limit;
  logic [2:0]  mode_q, mode_d;
  logic [7:0]  tag_q, tag_d;
  logic [2:0]  lol_q, lol_d;
  logic [31:0] lacc_q, lacc_d;
  logic [31:0] obl_q, obl_d;
  logic [31:0] aacc_q, aacc_d;
  logic        first_q, first_d;

  logic [7:0]  b;
  logic [31:0] lacc_shift;
  logic [31:0] arc_t;
  logic        lt40, lt80;
  logic [31:0] arc_hi, arc_lo;
  logic        len_fin;
  logic [31:0] len_val;
  logic [CntW-1:0] nres;
  out_item_t [MaxRes-1:0] ents;

  // length octet limit register, values above four act as four
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= MaxLenOctets;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  assign limit = (limit_q > MaxLenOctets) ? MaxLenOctets : limit_q;

  assign b          = item_i.data_byte;
  assign lacc_shift = {lacc_q[23:0], b};
  assign arc_t      = {aacc_q[24:0], b[6:0]};

  // x.690 split of the first subidentifier
  assign lt40   = arc_t < ArcSplit1;
  assign lt80   = arc_t < ArcSplit2;
  assign arc_hi = lt40 ? 32'd0 : (lt80 ? 32'd1 : 32'd2);
  assign arc_lo = lt40 ? arc_t : (lt80 ? (arc_t - ArcSplit1) : (arc_t - ArcSplit2));

  // next state and the events of this byte
  always_comb begin
    mode_d  = mode_q;
    tag_d   = tag_q;
    lol_d   = lol_q;
    lacc_d  = lacc_q;
    obl_d   = obl_q;
    aacc_d  = aacc_q;
    first_d = first_q;
    ents    = '0;
    nres    = '0;
    len_fin = 1'b0;
    len_val = '0;

    case (mode_q)
      MODE_TAG: begin
        tag_d = b;
        if (b == TagSeq) begin
          ents[nres[1:0]] = mk_item(EV_SEQ, b, 32'd0);
          nres = nres + 3'd1;
          mode_d = MODE_LEN;
        end else if (b == TagOid) begin
          ents[nres[1:0]] = mk_item(EV_OIDTAG, b, 32'd0);
          nres = nres + 3'd1;
          mode_d = MODE_LEN;
        end else if (b != TagSet && (b & ConsBit) != 8'd0) begin
          ents[nres[1:0]] = mk_item(EV_CONS, b, 32'd0);
          nres = nres + 3'd1;
          mode_d = MODE_LEN;
        end else begin
          ents[nres[1:0]] = mk_item(EV_BADTAG, b, 32'd0);
          nres = nres + 3'd1;
          mode_d = MODE_HALT;
        end
      end
      MODE_LEN: begin
        if (!b[7]) begin
          len_fin = 1'b1;
          len_val = {24'd0, b};
        end else if (b[6:0] == 7'd0 || b[6:0] > {4'd0, limit}) begin
          ents[nres[1:0]] = mk_item(EV_BADLEN, tag_q, 32'd0);
          nres = nres + 3'd1;
          mode_d = MODE_HALT;
        end else begin
          lol_d  = b[2:0];
          lacc_d = '0;
          mode_d = MODE_LONG;
        end
      end
      MODE_LONG: begin
        lacc_d = lacc_shift;
        lol_d  = lol_q - 3'd1;
        if (lol_d == 3'd0) begin
          len_fin = 1'b1;
          len_val = lacc_shift;
        end
      end
      MODE_OID: begin
        aacc_d = arc_t;
        obl_d  = obl_q - 32'd1;
        if (!b[7]) begin
          if (!first_q) begin
            ents[nres[1:0]] = mk_item(EV_ARC, tag_q, arc_hi);
            nres = nres + 3'd1;
            ents[nres[1:0]] = mk_item(EV_ARC, tag_q, arc_lo);
            nres = nres + 3'd1;
            first_d = 1'b1;
          end else begin
            ents[nres[1:0]] = mk_item(EV_ARC, tag_q, arc_t);
            nres = nres + 3'd1;
          end
          aacc_d = '0;
        end
        if (obl_d == 32'd0) begin
          ents[nres[1:0]] = mk_item(EV_OIDEND, tag_q, 32'd0);
          nres = nres + 3'd1;
          aacc_d  = '0;
          first_d = 1'b0;
          mode_d  = MODE_TAG;
        end
      end
      default: begin
      end
    endcase

    // a finished length, and for an oid the start of its body, or its end when empty
    if (len_fin) begin
      ents[nres[1:0]] = mk_item(EV_LENGTH, tag_d, len_val);
      nres = nres + 3'd1;
      if (tag_d == TagOid) begin
        if (len_val == 32'd0) begin
          ents[nres[1:0]] = mk_item(EV_OIDEND, tag_d, 32'd0);
          nres = nres + 3'd1;
          mode_d = MODE_TAG;
        end else begin
          obl_d   = len_val;
          aacc_d  = '0;
          first_d = 1'b0;
          mode_d  = MODE_OID;
        end
      end else begin
        mode_d = MODE_TAG;
      end
    end

    // message end: flag an open element, then rearm
    if (item_i.message_end) begin
      if (mode_d inside {MODE_LEN, MODE_LONG, MODE_OID}) begin
        ents[nres[1:0]] = mk_item(EV_TRUNC, tag_d, 32'd0);
        nres = nres + 3'd1;
      end
      mode_d  = MODE_TAG;
      tag_d   = '0;
      lol_d   = '0;
      lacc_d  = '0;
      obl_d   = '0;
      aacc_d  = '0;
      first_d = 1'b0;
    end
  end

  assign bundle_o.ents = ents;
  assign bundle_o.cnt  = nres;

  // parser state, advanced once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_TAG;
      tag_q   <= '0;
      lol_q   <= '0;
      lacc_q  <= '0;
      obl_q   <= '0;
      aacc_q  <= '0;
      first_q <= 1'b0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      tag_q   <= tag_d;
      lol_q   <= lol_d;
      lacc_q  <= lacc_d;
      obl_q   <= obl_d;
      aacc_q  <= aacc_d;
      first_q <= first_d;
    end
  end

  `ASSERT_PROP(a_halt_silent, (mode_q == MODE_HALT) |-> (bundle_o.cnt == 3'd0),
               "halted parser produced events")
  `ASSERT_PROP(a_end_rearms, (fire_i && item_i.message_end) |=> (mode_q == MODE_TAG),
               "message end did not rearm parser")
  `ASSERT_NEVER(a_bundle_size, bundle_o.cnt > 3'd3, "more than three events for one byte")

endmodule

// ===== src/dtw_result_buf.sv =====
// result bundle register that hands out one event per cycle while the output is ready
// depends on dtw_pkg and assert_macros.svh
`include "assert_macros.svh"
module dtw_result_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  dtw_pkg::res_bundle_t bundle_i,
  output logic                 can_load_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dtw_pkg::out_item_t   out_item_o
);
  import dtw_pkg::*;

  out_item_t [MaxRes-1:0] ents_q;
  logic [CntW-1:0]        cnt_q;
  logic [1:0]             rd_q;
  logic                   is_last;
  logic                   out_fire;

  assign out_valid_o = cnt_q != '0;
  assign out_fire    = out_valid_o && out_ready_i;
  assign is_last     = ({1'b0, rd_q} + 3'd1) == cnt_q;
  assign can_load_o  = !out_valid_o || (out_fire && is_last);

  // current event, flagged when it is the last of its byte
  always_comb begin
    out_item_o             = ents_q[rd_q];
    out_item_o.last_of_run = is_last;
  end

  // bundle payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ents_q <= bundle_i.ents;
    end
  end

  // read pointer and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (load_i) begin
      cnt_q <= bundle_i.cnt;
      rd_q  <= '0;
    end else if (out_fire) begin
      if (is_last) begin
        cnt_q <= '0;
        rd_q  <= '0;
      end else begin
        rd_q <= rd_q + 2'd1;
      end
    end
  end

  `ASSERT_PROP(a_rd_in_range, out_valid_o |-> ({1'b0, rd_q} < cnt_q),
               "read pointer beyond bundle")
  `ASSERT_PROP(a_load_when_free, load_i |-> can_load_o, "bundle overwritten while busy")
  `ASSERT_PROP(a_step, (out_fire && !is_last) |=> (rd_q == $past(rd_q) + 2'd1),
               "read pointer did not advance")

endmodule

// ===== src/der_tlv_stream_walker.sv =====
// An item enters the input register and is decoded combinationally into a
// bundle of up to three events, which leave one per cycle while the output
// is ready. Bytes also pass one per cycle then, while each causes at most
// one event; a byte with more events holds the decoder until all have left.
// Reset is asynchronous, active low; it empties both registers and rearms
// the parser with the length limit at four.
// top level of the der tlv stream walker; depends on dtw_pkg, dtw_parse,
// dtw_result_buf
module der_tlv_stream_walker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dtw_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dtw_pkg::out_item_t out_item_o
);
  import dtw_pkg::*;

  in_item_t    in_q;
  logic        in_v_q;
  logic        can_load;
  logic        proc;
  res_bundle_t bundle;

  // decode the held item when the result bundle is free
  assign proc       = in_v_q && can_load;
  assign in_ready_o = !in_v_q || proc;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  dtw_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (proc),
    .item_i      (in_q),
    .bundle_o    (bundle)
  );

  dtw_result_buf u_res (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (proc),
    .bundle_i    (bundle),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== test/der_tlv_walk_checker.sv =====
// checker for the der tlv stream walker: watches config, input and output items,
// predicts the events of each byte and compares them in order
// depends on dtw_pkg for the item types, parse modes and event kinds
`timescale 1ns / 1ps

module der_tlv_walk_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  dtw_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  dtw_pkg::out_item_t out_item_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o
);
  import dtw_pkg::*;

  // predicted walker state
  logic [2:0]  walk_mode;
  logic [7:0]  cur_tag;
  logic [2:0]  len_octets_left;
  logic [31:0] len_acc;
  logic [31:0] oid_left;
  logic [31:0] arc_acc;
  logic        first_arc_done;
  logic [2:0]  len_limit_reg;

  out_item_t byte_events[$];
  out_item_t pending_events[$];
  int        mismatches;
  int        checked;
  int        pending_size;

  assign fail_count_o = mismatches;
  assign pending_o    = pending_size;
  assign checked_o    = checked;

  function automatic void note_event(logic [3:0] kind, logic [7:0] tag, logic [31:0] val);
    out_item_t e;
    e.event_kind  = kind;
    e.tag_value   = tag;
    e.event_value = val;
    e.last_of_run = 1'b0;
    byte_events.push_back(e);
  endfunction

  function automatic void clear_walk();
    walk_mode       = MODE_TAG;
    cur_tag         = 8'd0;
    len_octets_left = 3'd0;
    len_acc         = 32'd0;
    oid_left        = 32'd0;
    arc_acc         = 32'd0;
    first_arc_done  = 1'b0;
  endfunction

  // length known: report it, then either enter the oid body or go back to tags
  function automatic void close_length(logic [31:0] len);
    note_event(EV_LENGTH, cur_tag, len);
    if (cur_tag == TagOid) begin
      if (len == 32'd0) begin
        note_event(EV_OIDEND, cur_tag, 32'd0);
        walk_mode = MODE_TAG;
      end else begin
        oid_left       = len;
        arc_acc        = 32'd0;
        first_arc_done = 1'b0;
        walk_mode      = MODE_OID;
      end
    end else begin
      walk_mode = MODE_TAG;
    end
  endfunction

  // events caused by one accepted byte, appended to the expected queue
  function automatic void walk_der_byte(in_item_t it);
    logic [7:0]  b;
    logic [2:0]  limit;
    logic [31:0] t;
    logic [31:0] hi;
    out_item_t   e;
    b     = it.data_byte;
    limit = (len_limit_reg > MaxLenOctets) ? MaxLenOctets : len_limit_reg;
    byte_events.delete();
    case (walk_mode)
      MODE_TAG: begin
        cur_tag = b;
        if (b == TagSeq) begin
          note_event(EV_SEQ, b, 32'd0);
          walk_mode = MODE_LEN;
        end else if (b == TagOid) begin
          note_event(EV_OIDTAG, b, 32'd0);
          walk_mode = MODE_LEN;
        end else if (b != TagSet && (b & ConsBit) != 8'd0) begin
          note_event(EV_CONS, b, 32'd0);
          walk_mode = MODE_LEN;
        end else begin
          note_event(EV_BADTAG, b, 32'd0);
          walk_mode = MODE_HALT;
        end
      end
      MODE_LEN: begin
        if (!b[7]) begin
          close_length({24'd0, b});
        end else if (b[6:0] == 7'd0 || b[6:0] > {4'd0, limit}) begin
          // indefinite length or more octets than allowed
          note_event(EV_BADLEN, cur_tag, 32'd0);
          walk_mode = MODE_HALT;
        end else begin
          len_octets_left = b[2:0];
          len_acc         = 32'd0;
          walk_mode       = MODE_LONG;
        end
      end
      MODE_LONG: begin
        len_acc         = {len_acc[23:0], b};
        len_octets_left = len_octets_left - 3'd1;
        if (len_octets_left == 3'd0) close_length(len_acc);
      end
      MODE_OID: begin
        arc_acc  = {arc_acc[24:0], b[6:0]};
        oid_left = oid_left - 32'd1;
        if (!b[7]) begin
          t = arc_acc;
          if (!first_arc_done) begin
            // first subidentifier carries two arcs
            hi = (t < ArcSplit1) ? 32'd0 : ((t < ArcSplit2) ? 32'd1 : 32'd2);
            note_event(EV_ARC, cur_tag, hi);
            note_event(EV_ARC, cur_tag, t - ArcSplit1 * hi);
            first_arc_done = 1'b1;
          end else begin
            note_event(EV_ARC, cur_tag, t);
          end
          arc_acc = 32'd0;
        end
        // a dangling continuation byte is dropped here
        if (oid_left == 32'd0) begin
          note_event(EV_OIDEND, cur_tag, 32'd0);
          arc_acc        = 32'd0;
          first_arc_done = 1'b0;
          walk_mode      = MODE_TAG;
        end
      end
      default: ;
    endcase
    if (it.message_end) begin
      if (walk_mode == MODE_LEN || walk_mode == MODE_LONG || walk_mode == MODE_OID)
        note_event(EV_TRUNC, cur_tag, 32'd0);
      clear_walk();
    end
    if (byte_events.size() > 0) begin
      e = byte_events.pop_back();
      e.last_of_run = 1'b1;
      byte_events.push_back(e);
    end
    foreach (byte_events[i]) pending_events.push_back(byte_events[i]);
  endfunction

  function automatic void compare_field(string field_name, logic [31:0] want,
                                        logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field_name, want, got);
    end
  endfunction

  // config, input and output items sampled at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      clear_walk();
      len_limit_reg = MaxLenOctets;
      pending_events.delete();
      mismatches   = 0;
      checked      = 0;
      pending_size = 0;
    end else begin
      if (cfg_we_i) len_limit_reg = cfg_wdata_i;
      if (in_valid_i && in_ready_i) walk_der_byte(in_item_i);
      if (out_valid_i && out_ready_i) begin
        if (pending_events.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected event, expected none, actual kind %0d tag %h value %h",
                   $time, out_item_i.event_kind, out_item_i.tag_value,
                   out_item_i.event_value);
        end else begin
          want = pending_events.pop_front();
          checked++;
          compare_field("event_kind", {28'd0, want.event_kind}, {28'd0, out_item_i.event_kind});
          compare_field("tag_value", {24'd0, want.tag_value}, {24'd0, out_item_i.tag_value});
          compare_field("event_value", want.event_value, out_item_i.event_value);
          compare_field("last_of_run", {31'd0, want.last_of_run},
                        {31'd0, out_item_i.last_of_run});
        end
      end
      pending_size = pending_events.size();
    end
  end

endmodule

// ===== test/tb_der_tlv_stream_walker.sv =====
// testbench top for der_tlv_stream_walker: drives der byte streams with random
// gaps and output stalls, sweeps the length-octet limit and gives the verdict
// depends on dtw_pkg, der_tlv_stream_walker and der_tlv_walk_checker
`timescale 1ns / 1ps

module tb_der_tlv_stream_walker;
  import dtw_pkg::*;

  localparam int IdleCycles  = 12;
  localparam int StallCycles = 200;
  localparam int PhaseBytes  = 55;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      cfg_we_i;
  logic [2:0] cfg_wdata_i;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  int fail_count;
  int pending_count;
  int checked_count;

  int         bytes_sent    = 0;
  int         messages_sent = 0;
  logic [2:0] cur_limit     = MaxLenOctets;
  bit         no_gaps       = 1'b0;
  bit         stall_wanted  = 1'b0;
  bit         stall_done    = 1'b0;
  logic [7:0] msg_bytes[$];
  logic [8:0] directed[$];
  logic [2:0] limit_sweep[$];

  der_tlv_stream_walker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  der_tlv_walk_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_item_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_count),
    .checked_o    (checked_count)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // long-form octet count: mostly legal, sometimes indefinite or too many
  function automatic int pick_octets();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(5, 7);
    if (r == 2) return cur_limit + 1;
    return $urandom_range(1, (cur_limit == 3'd0) ? 1 : cur_limit);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int       gap;
    in_item_t it;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it.data_byte   = b;
    it.message_end = last;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // short form, or long form big-endian in the given number of octets
  task automatic push_length(input logic [31:0] len, input bit long_form, input int octets);
    logic [31:0] sh;
    if (!long_form) begin
      msg_bytes.push_back({1'b0, len[6:0]});
    end else begin
      sh = 32'h80 | octets;
      msg_bytes.push_back(sh[7:0]);
      for (int i = octets - 1; i >= 0; i--) begin
        sh = (i >= 4) ? 32'd0 : (len >> (8 * i));
        msg_bytes.push_back(sh[7:0]);
      end
    end
  endtask

  // one random message: mostly a well-formed sequence, sometimes noise,
  // sometimes cut short
  task automatic send_message();
    logic [7:0]  body[$];
    logic [7:0]  rb;
    logic [7:0]  tag;
    logic [31:0] len;
    int          groups;
    int          cut;
    msg_bytes.delete();
    if ($urandom_range(0, 9) < 2) begin
      repeat ($urandom_range(1, 8)) begin
        rb = $urandom_range(0, 255);
        msg_bytes.push_back(rb);
      end
    end else begin
      msg_bytes.push_back(TagSeq);
      push_length($urandom, $urandom_range(0, 3) == 0, pick_octets());
      repeat ($urandom_range(1, 5)) begin
        if ($urandom_range(0, 9) < 4) begin
          // object identifier with random arcs
          body.delete();
          repeat ($urandom_range(1, 4)) begin
            groups = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 5) : $urandom_range(1, 2);
            for (int g = groups - 1; g >= 0; g--) begin
              rb = $urandom_range(0, 127);
              body.push_back((g > 0) ? (rb | 8'h80) : rb);
            end
          end
          if ($urandom_range(0, 5) == 0) begin
            rb = $urandom_range(0, 127);
            body.push_back(rb | 8'h80);
          end
          msg_bytes.push_back(TagOid);
          if ($urandom_range(0, 3) == 0)
            push_length(body.size(), 1'b1, pick_octets());
          else
            push_length(body.size(), 1'b0, 0);
          foreach (body[i]) msg_bytes.push_back(body[i]);
        end else begin
          // sequence or another constructed tag with a random length
          rb  = $urandom_range(0, 255);
          tag = ($urandom_range(0, 1) == 0) ? TagSeq : (rb | ConsBit);
          len = $urandom;
          msg_bytes.push_back(tag);
          push_length(len, $urandom_range(0, 3) == 0, pick_octets());
        end
      end
    end
    if ($urandom_range(0, 99) < 15) begin
      cut = $urandom_range(1, msg_bytes.size());
      while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
    end
    foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    messages_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (IdleCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [2:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_limit = (value > MaxLenOctets) ? MaxLenOctets : value;
  endtask

  // output side: random stalls, and one long hold-off on request
  initial begin
    int gap;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (stall_wanted && !stall_done) begin
        out_ready_i <= 1'b0;
        repeat (StallCycles) @(posedge clk_i);
        stall_done = 1'b1;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  // stimulus and verdict
  initial begin
    int phase_start;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 3'd0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: {message_end, byte}
    directed = '{
      // sequence, oid 1.2.840
      {1'b0, TagSeq}, {1'b0, 8'h08}, {1'b0, TagOid}, {1'b0, 8'h03},
      {1'b0, 8'h2A}, {1'b0, 8'h86}, {1'b1, 8'h48},
      // all-ones constructed tag, max short length, then set is rejected
      {1'b0, 8'hFF}, {1'b0, 8'h7F}, {1'b0, TagSet}, {1'b1, 8'h44},
      // four length octets, all ones
      {1'b0, TagSeq}, {1'b0, 8'h84}, {1'b0, 8'hFF}, {1'b0, 8'hFF},
      {1'b0, 8'hFF}, {1'b1, 8'hFF},
      // empty oid
      {1'b0, TagOid}, {1'b1, 8'h00},
      // indefinite length
      {1'b0, TagSeq}, {1'b0, 8'h80}, {1'b1, 8'h12},
      // first arc in the top band, body ends mid-arc
      {1'b0, TagOid}, {1'b0, 8'h03}, {1'b0, 8'h81}, {1'b0, 8'h10}, {1'b1, 8'hFF},
      // zero tag rejected on the final byte
      {1'b1, 8'h00},
      // oid body cut short
      {1'b0, TagOid}, {1'b0, 8'h05}, {1'b1, 8'h2B},
      // tag without its length
      {1'b1, TagSeq},
      // five length octets
      {1'b0, TagSeq}, {1'b1, 8'h85}
    };
    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);
    messages_sent += 10;

    // random messages under a sweep of length-octet limits
    limit_sweep = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd4};
    foreach (limit_sweep[p]) begin
      wait_idle();
      write_limit(limit_sweep[p]);
      stall_wanted = (p == 2);
      no_gaps      = (p == 4);
      phase_start  = bytes_sent;
      while (bytes_sent < phase_start + PhaseBytes) send_message();
    end
    no_gaps = 1'b0;
    wait_idle();

    $display("walked %0d bytes in %0d messages, %0d events checked", bytes_sent,
             messages_sent, checked_count);
    $display("limits 4,1,0,7,2,3,4 swept; one long output hold-off and one gap-free phase");
    if (fail_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("timeout with %0d events outstanding", pending_count);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
